### src/cwcc_pkg.sv
// ============================================================================
// cwcc_pkg
// Shared types and constants of the channel window credit controller.
// ============================================================================
package cwcc_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int LENGTH_BITS = 18;

    localparam int WINDOW_BITS = 32;
    localparam int MAXPKT_BITS = 18;
    localparam int CFG_IDX_BITS = 2;

    localparam logic [WINDOW_BITS-1:0] WINDOW_SIZE_RESET = 32'd1048576;
    localparam logic [MAXPKT_BITS-1:0] MAX_PACKET_RESET = 18'd32768;

    localparam logic [CFG_IDX_BITS-1:0] CFG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PACKET = 2'd1;

    localparam logic [2:0] FUNC_OPEN_REQ = 3'd0;
    localparam logic [2:0] FUNC_OPEN_CONFIRM = 3'd1;
    localparam logic [2:0] FUNC_PEER_ADJUST = 3'd2;
    localparam logic [2:0] FUNC_SUCCESS = 3'd3;
    localparam logic [2:0] FUNC_DATA_IN = 3'd4;
    localparam logic [2:0] FUNC_CLOSED = 3'd5;
    localparam logic [2:0] FUNC_PUSH = 3'd6;
    localparam logic [2:0] FUNC_POP = 3'd7;

    typedef struct packed {
        logic push;
        logic pop;
    } q_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

### src/cwcc_ifs.sv
// ============================================================================
// cwcc channel interfaces
// Event, result and configuration channels with valid/ready handshakes.
// ============================================================================
interface cwcc_evt_if #(
    parameter int LENGTH_BITS = cwcc_pkg::LENGTH_BITS
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             func;
    logic [31:0]            amount;
    logic [LENGTH_BITS-1:0] length;

    modport source (output valid, output func, output amount, output length, input ready);
    modport sink (input valid, input func, input amount, input length, output ready);
endinterface

interface cwcc_res_if #(
    parameter int LENGTH_BITS = cwcc_pkg::LENGTH_BITS,
    parameter int QUEUE_DEPTH = cwcc_pkg::QUEUE_DEPTH
);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic                   valid;
    logic                   ready;
    logic                   adjust_send;
    logic [31:0]            adjust_amount;
    logic                   popped;
    logic [LENGTH_BITS-1:0] popped_length;
    logic                   push_rejected;
    logic                   window_underrun;
    logic                   is_open;
    logic [31:0]            peer_credit;
    logic [CNT_W-1:0]       queued;

    modport source (output valid, output adjust_send, output adjust_amount, output popped,
                    output popped_length, output push_rejected, output window_underrun,
                    output is_open, output peer_credit, output queued, input ready);
    modport sink (input valid, input adjust_send, input adjust_amount, input popped,
                  input popped_length, input push_rejected, input window_underrun,
                  input is_open, input peer_credit, input queued, output ready);
endinterface

interface cwcc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [cwcc_pkg::CFG_IDX_BITS-1:0]   index;
    logic [31:0]                         data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### src/cwcc_ram.sv
// ============================================================================
// cwcc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ============================================================================
module cwcc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

### src/cwcc_queue.sv
// ============================================================================
// cwcc_queue
// Pending packet length queue held in RAM, with the head entry always ready.
// ============================================================================
module cwcc_queue #(
    parameter int DEPTH = cwcc_pkg::QUEUE_DEPTH,
    parameter int DW = cwcc_pkg::LENGTH_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cwcc_pkg::q_cmd_t             cmd,
    input  logic [DW-1:0]                push_data,
    output cwcc_pkg::q_stat_t            stat,
    output logic [$clog2(DEPTH+1)-1:0]   count,
    output logic [DW-1:0]                head_data
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic          byp_valid_reg, byp_valid_next;
    logic [DW-1:0] byp_data_reg;
    logic [DW-1:0] rd_data;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        head_next = cmd.pop ? ptr_inc(head_reg) : head_reg;
        tail_next = cmd.push ? ptr_inc(tail_reg) : tail_reg;
        count_next = count_reg;
        if (cmd.push)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - 1'b1;
        end
        byp_valid_next = cmd.push && (tail_reg == head_next);
    end

    cwcc_ram #(
        .WIDTH (DW),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (cmd.push),
        .wr_addr (tail_reg),
        .wr_data (push_data),
        .rd_addr (head_next),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            byp_valid_reg <= byp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byp_valid_next)
        begin
            byp_data_reg <= push_data;
        end
    end

    assign head_data  = byp_valid_reg ? byp_data_reg : rd_data;
    assign count      = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == CW'(DEPTH));

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> count_reg != CW'(DEPTH))
        else $error("push into a full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.pop |-> count_reg != '0)
        else $error("pop from an empty queue");
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg == '0 |-> head_reg == tail_reg)
        else $error("empty queue with head and tail apart");
`endif

endmodule

### src/channel_window_credit_control.sv
// ============================================================================
// channel_window_credit_control
// Credit-based window flow control for one multiplexed channel.
// ============================================================================
// Events enter on the evt channel, one item per accepted handshake, and each
// event yields exactly one result item on the res channel. The result is
// registered: it appears in the cycle after the event is accepted. A new event
// is taken every cycle as long as the res register is empty or is being
// drained in the same cycle, so throughput is one item per cycle. The
// per-cycle path is the window update followed by the adjust threshold add
// and compare. Pending packet lengths live in a RAM whose next head entry is
// read ahead every cycle, with a bypass for a push into an empty queue, so
// back-to-back pops and pushes run at full rate. When the receiver stalls,
// the result holds and evt.ready drops until it is taken. The cfg channel
// is always ready and writes window_size or max_packet; it is meant to be
// used only while no event is in flight. Reset restores the default
// registers, closes the channel, clears peer credit and empties the queue;
// there is no clearing pass.
// ============================================================================
module channel_window_credit_control #(
    parameter int QUEUE_DEPTH = cwcc_pkg::QUEUE_DEPTH,
    parameter int LENGTH_BITS = cwcc_pkg::LENGTH_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    cwcc_evt_if.sink    evt,
    cwcc_res_if.source  res,
    cwcc_cfg_if.sink    cfg
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int WB = cwcc_pkg::WINDOW_BITS;
    localparam int MB = cwcc_pkg::MAXPKT_BITS;

    logic [WB-1:0]          ws_reg;
    logic [MB-1:0]          mp_reg;
    logic                   open_reg, open_next;
    logic [WB-1:0]          lw_reg, lw_next, lw_mid;
    logic [WB-1:0]          pw_reg, pw_next;
    logic [LENGTH_BITS-1:0] pml_reg, pml_next;

    logic                   accept;
    logic                   check;
    logic [WB:0]            credit_sum;
    logic [WB+1:0]          threshold;
    logic [WB-1:0]          len_ext;
    logic [WB-1:0]          head_ext;

    cwcc_pkg::q_cmd_t       q_cmd;
    cwcc_pkg::q_stat_t      q_stat;
    logic [CNT_W-1:0]       q_count;
    logic [LENGTH_BITS-1:0] q_head;

    logic                   o_valid_reg;
    logic                   o_adj_send_next, o_adj_send_reg;
    logic [WB-1:0]          o_adj_amt_next, o_adj_amt_reg;
    logic                   o_popped_reg;
    logic [LENGTH_BITS-1:0] o_pop_len_next, o_pop_len_reg;
    logic                   o_rejected_next, o_rejected_reg;
    logic                   o_underrun_next, o_underrun_reg;
    logic                   o_open_reg;
    logic [WB-1:0]          o_credit_reg;
    logic [CNT_W-1:0]       o_queued_next, o_queued_reg;

    assign evt.ready = !o_valid_reg || res.ready;
    assign accept    = evt.valid && evt.ready;
    assign cfg.ready = 1'b1;

    assign len_ext  = WB'(evt.length);
    assign head_ext = WB'(q_head);

    always_comb
    begin
        open_next       = open_reg;
        lw_mid          = lw_reg;
        pw_next         = pw_reg;
        pml_next        = pml_reg;
        check           = 1'b0;
        q_cmd.push      = 1'b0;
        q_cmd.pop       = 1'b0;
        o_rejected_next = 1'b0;
        o_underrun_next = 1'b0;
        o_pop_len_next  = '0;
        credit_sum      = {1'b0, pw_reg} + {1'b0, evt.amount};

        unique case (evt.func)
            cwcc_pkg::FUNC_OPEN_REQ:
            begin
                lw_mid = ws_reg;
            end
            cwcc_pkg::FUNC_OPEN_CONFIRM:
            begin
                pw_next  = evt.amount;
                pml_next = evt.length;
            end
            cwcc_pkg::FUNC_PEER_ADJUST:
            begin
                pw_next = credit_sum[WB] ? '1 : credit_sum[WB-1:0];
                check   = 1'b1;
            end
            cwcc_pkg::FUNC_SUCCESS:
            begin
                open_next = 1'b1;
                check     = 1'b1;
            end
            cwcc_pkg::FUNC_DATA_IN:
            begin
                if (len_ext > lw_reg)
                begin
                    lw_mid          = '0;
                    o_underrun_next = 1'b1;
                end
                else
                begin
                    lw_mid = lw_reg - len_ext;
                end
                check = 1'b1;
            end
            cwcc_pkg::FUNC_CLOSED:
            begin
                open_next = 1'b0;
            end
            cwcc_pkg::FUNC_PUSH:
            begin
                if (q_stat.full || (evt.length >= pml_reg))
                begin
                    o_rejected_next = 1'b1;
                end
                else
                begin
                    q_cmd.push = accept;
                end
            end
            cwcc_pkg::FUNC_POP:
            begin
                if (!q_stat.empty && (head_ext < pw_reg))
                begin
                    q_cmd.pop      = accept;
                    o_pop_len_next = q_head;
                    pw_next        = pw_reg - head_ext;
                end
            end
            default:
            begin
                lw_mid = lw_reg;
            end
        endcase

        threshold       = {2'b00, lw_mid} + (WB+2)'({mp_reg, 1'b0});
        o_adj_send_next = check && open_next && (threshold < {2'b00, ws_reg});
        o_adj_amt_next  = o_adj_send_next ? (ws_reg - lw_mid) : '0;
        lw_next         = o_adj_send_next ? ws_reg : lw_mid;

        o_queued_next = q_count;
        if (q_cmd.push)
        begin
            o_queued_next = q_count + 1'b1;
        end
        else if (q_cmd.pop)
        begin
            o_queued_next = q_count - 1'b1;
        end
    end

    cwcc_queue #(
        .DEPTH (QUEUE_DEPTH),
        .DW    (LENGTH_BITS)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .push_data (evt.length),
        .stat      (q_stat),
        .count     (q_count),
        .head_data (q_head)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg      <= cwcc_pkg::WINDOW_SIZE_RESET;
            mp_reg      <= cwcc_pkg::MAX_PACKET_RESET;
            open_reg    <= 1'b0;
            lw_reg      <= cwcc_pkg::WINDOW_SIZE_RESET;
            pw_reg      <= '0;
            pml_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid && (cfg.index == cwcc_pkg::CFG_WINDOW_SIZE))
            begin
                ws_reg <= cfg.data;
            end
            if (cfg.valid && (cfg.index == cwcc_pkg::CFG_MAX_PACKET))
            begin
                mp_reg <= cfg.data[MB-1:0];
            end
            if (accept)
            begin
                open_reg    <= open_next;
                lw_reg      <= lw_next;
                pw_reg      <= pw_next;
                pml_reg     <= pml_next;
                o_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            o_adj_send_reg <= o_adj_send_next;
            o_adj_amt_reg  <= o_adj_amt_next;
            o_popped_reg   <= q_cmd.pop;
            o_pop_len_reg  <= o_pop_len_next;
            o_rejected_reg <= o_rejected_next;
            o_underrun_reg <= o_underrun_next;
            o_open_reg     <= open_next;
            o_credit_reg   <= pw_next;
            o_queued_reg   <= o_queued_next;
        end
    end

    assign res.valid           = o_valid_reg;
    assign res.adjust_send     = o_adj_send_reg;
    assign res.adjust_amount   = o_adj_amt_reg;
    assign res.popped          = o_popped_reg;
    assign res.popped_length   = o_pop_len_reg;
    assign res.push_rejected   = o_rejected_reg;
    assign res.window_underrun = o_underrun_reg;
    assign res.is_open         = o_open_reg;
    assign res.peer_credit     = o_credit_reg;
    assign res.queued          = o_queued_reg;

`ifndef ASSERT_OFF
    a_adjust_open: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_adj_send_reg |-> o_open_reg)
        else $error("window adjust sent on a closed channel");
    a_queued_bound: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg |-> o_queued_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queued count beyond queue depth");
    a_pop_matches_queue: assert property (@(posedge clk) disable iff (!rst_n)
        accept && q_cmd.pop |=> o_queued_reg == $past(q_count) - 1'b1)
        else $error("pop result does not match queue count");
    a_reject_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        o_valid_reg && o_rejected_reg |-> !o_popped_reg && !o_adj_send_reg)
        else $error("rejected push reported with other activity");
`endif

endmodule

### bench/channel_window_credit_control_test.sv
`timescale 1ns / 1ps
// ============================================================================
// channel_window_credit_control_test
// Self-checking bench for the channel window credit controller. A behavioral
// predictor tracks the open flag, both windows, the peer packet limit and the
// pending length queue, and every result item is compared field by field
// against the oldest prediction. Directed events, a backpressure run and
// random channel sessions under several register settings are applied with
// random idling on both sides, which the final traffic run turns off.
// ============================================================================
module channel_window_credit_control_test;

    localparam int LEN_W = cwcc_pkg::LENGTH_BITS;
    localparam int CNT_W = $clog2(cwcc_pkg::QUEUE_DEPTH + 1);

    typedef struct packed {
        logic             adjust_send;
        logic [31:0]      adjust_amount;
        logic             popped;
        logic [LEN_W-1:0] popped_length;
        logic             push_rejected;
        logic             window_underrun;
        logic             is_open;
        logic [31:0]      peer_credit;
        logic [CNT_W-1:0] queued;
    } channel_result_t;

    logic clk;
    logic rst_n;

    cwcc_evt_if evt_ch ();
    cwcc_res_if res_ch ();
    cwcc_cfg_if cfg_ch ();

    channel_window_credit_control u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    logic [31:0]      cfg_window_size = cwcc_pkg::WINDOW_SIZE_RESET;
    logic [17:0]      cfg_max_packet = cwcc_pkg::MAX_PACKET_RESET;
    logic             open_state = 1'b0;
    logic [31:0]      rx_window = cwcc_pkg::WINDOW_SIZE_RESET;
    logic [31:0]      tx_credit = '0;
    logic [LEN_W-1:0] peer_pkt_limit = '0;
    logic [LEN_W-1:0] pending_lengths[$];

    channel_result_t awaited_results[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holdoff_cycles = 0;
    int holdoff_seq = 0;
    logic holding = 1'b0;

    int error_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int config_writes = 0;
    int adjusts_seen = 0;
    int pops_seen = 0;
    int rejects_seen = 0;
    int underruns_seen = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic channel_result_t next_channel_result(
        input logic [2:0]       func,
        input logic [31:0]      amount,
        input logic [LEN_W-1:0] length
    );
        channel_result_t r;
        logic            check_adjust;
        logic [32:0]     credit_sum;
        logic [33:0]     threshold_lhs;
        logic [LEN_W-1:0] head;
        r = '0;
        check_adjust = 1'b0;
        case (func)
            cwcc_pkg::FUNC_OPEN_REQ: rx_window = cfg_window_size;
            cwcc_pkg::FUNC_OPEN_CONFIRM:
            begin
                tx_credit = amount;
                peer_pkt_limit = length;
            end
            cwcc_pkg::FUNC_PEER_ADJUST:
            begin
                credit_sum = {1'b0, tx_credit} + {1'b0, amount};
                tx_credit = credit_sum[32] ? 32'hFFFF_FFFF : credit_sum[31:0];
                check_adjust = 1'b1;
            end
            cwcc_pkg::FUNC_SUCCESS:
            begin
                open_state = 1'b1;
                check_adjust = 1'b1;
            end
            cwcc_pkg::FUNC_DATA_IN:
            begin
                if (32'(length) > rx_window)
                begin
                    rx_window = '0;
                    r.window_underrun = 1'b1;
                end
                else
                begin
                    rx_window = rx_window - 32'(length);
                end
                check_adjust = 1'b1;
            end
            cwcc_pkg::FUNC_CLOSED: open_state = 1'b0;
            cwcc_pkg::FUNC_PUSH:
            begin
                if (pending_lengths.size() >= cwcc_pkg::QUEUE_DEPTH ||
                    length >= peer_pkt_limit)
                    r.push_rejected = 1'b1;
                else
                    pending_lengths.insert(pending_lengths.size(), length);
            end
            default:
            begin
                if (pending_lengths.size() > 0 && 32'(pending_lengths[0]) < tx_credit)
                begin
                    head = pending_lengths[0];
                    pending_lengths.delete(0);
                    r.popped = 1'b1;
                    r.popped_length = head;
                    tx_credit = tx_credit - 32'(head);
                end
            end
        endcase
        threshold_lhs = {2'b00, rx_window} + {15'b0, cfg_max_packet, 1'b0};
        if (check_adjust && open_state && threshold_lhs < {2'b00, cfg_window_size})
        begin
            r.adjust_send = 1'b1;
            r.adjust_amount = cfg_window_size - rx_window;
            rx_window = cfg_window_size;
        end
        r.is_open = open_state;
        r.peer_credit = tx_credit;
        r.queued = CNT_W'(pending_lengths.size());
        return r;
    endfunction

    function automatic logic [31:0] rand_amount();
        case ($urandom_range(7, 0))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2, 3: return $urandom_range(65535, 0);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LEN_W-1:0] rand_length();
        case ($urandom_range(9, 0))
            0: return '0;
            1: return '1;
            2, 3, 4: return LEN_W'($urandom_range(4095, 0));
            default: return LEN_W'($urandom);
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [31:0] expected_value,
                                 input logic [31:0] actual_value);
        if (actual_value !== expected_value)
        begin
            $display("%0t: mismatch on %s, expected %h, actual %h", $time, name,
                     expected_value, actual_value);
            error_count++;
        end
    endtask

    task automatic check_result();
        channel_result_t exp_r;
        if (awaited_results.size() == 0)
        begin
            $display("%0t: result item with no outstanding event, actual %h", $time,
                     {res_ch.adjust_send, res_ch.adjust_amount, res_ch.popped,
                      res_ch.popped_length, res_ch.push_rejected, res_ch.window_underrun,
                      res_ch.is_open, res_ch.peer_credit, res_ch.queued});
            error_count++;
        end
        else
        begin
            exp_r = awaited_results[0];
            awaited_results.delete(0);
            compare_field("adjust_send", 32'(exp_r.adjust_send), 32'(res_ch.adjust_send));
            compare_field("adjust_amount", exp_r.adjust_amount, res_ch.adjust_amount);
            compare_field("popped", 32'(exp_r.popped), 32'(res_ch.popped));
            compare_field("popped_length", 32'(exp_r.popped_length),
                          32'(res_ch.popped_length));
            compare_field("push_rejected", 32'(exp_r.push_rejected),
                          32'(res_ch.push_rejected));
            compare_field("window_underrun", 32'(exp_r.window_underrun),
                          32'(res_ch.window_underrun));
            compare_field("is_open", 32'(exp_r.is_open), 32'(res_ch.is_open));
            compare_field("peer_credit", exp_r.peer_credit, res_ch.peer_credit);
            compare_field("queued", 32'(exp_r.queued), 32'(res_ch.queued));
            results_checked++;
            adjusts_seen += int'(exp_r.adjust_send);
            pops_seen += int'(exp_r.popped);
            rejects_seen += int'(exp_r.push_rejected);
            underruns_seen += int'(exp_r.window_underrun);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
            check_result();
    end

    initial
    begin
        res_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            res_ch.ready <= !holding && ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    initial
    begin
        int served;
        served = 0;
        forever
        begin
            @(posedge clk);
            if (holdoff_seq != served)
            begin
                served = holdoff_seq;
                holding = 1'b1;
                repeat (holdoff_cycles) @(posedge clk);
                holding = 1'b0;
            end
        end
    end

    task automatic send_event(input logic [2:0] func, input logic [31:0] amount,
                              input logic [LEN_W-1:0] length);
        @(negedge clk);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            evt_ch.valid <= 1'b0;
            @(negedge clk);
        end
        evt_ch.valid <= 1'b1;
        evt_ch.func <= func;
        evt_ch.amount <= amount;
        evt_ch.length <= length;
        @(posedge clk);
        while (!evt_ch.ready) @(posedge clk);
        awaited_results.insert(awaited_results.size(),
                               next_channel_result(func, amount, length));
        items_sent++;
    endtask

    task automatic wait_until_drained();
        @(negedge clk);
        evt_ch.valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge clk);
    endtask

    task automatic write_register(input logic [cwcc_pkg::CFG_IDX_BITS-1:0] index,
                                  input logic [31:0] data);
        wait_until_drained();
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        if (index == cwcc_pkg::CFG_WINDOW_SIZE)
            cfg_window_size = data;
        else if (index == cwcc_pkg::CFG_MAX_PACKET)
            cfg_max_packet = data[17:0];
        config_writes++;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_session(input int n);
        int pick;
        logic [LEN_W-1:0] push_len;
        if ($urandom_range(9, 0) < 8)
            send_event(cwcc_pkg::FUNC_OPEN_REQ, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_OPEN_CONFIRM, $urandom_range(32'hFFFF_FFFF, 32'h0010_0000),
                   LEN_W'($urandom_range(262143, 1)));
        send_event(cwcc_pkg::FUNC_SUCCESS, $urandom, LEN_W'($urandom));
        repeat (n)
        begin
            pick = $urandom_range(99, 0);
            if (pick < 25)
            begin
                send_event(cwcc_pkg::FUNC_DATA_IN, $urandom, rand_length());
            end
            else if (pick < 45)
            begin
                if (peer_pkt_limit > 0 && $urandom_range(99, 0) < 85)
                    push_len = LEN_W'($urandom_range(32'(peer_pkt_limit) - 1, 0));
                else
                    push_len = rand_length();
                send_event(cwcc_pkg::FUNC_PUSH, $urandom, push_len);
            end
            else if (pick < 68)
                send_event(cwcc_pkg::FUNC_POP, $urandom, LEN_W'($urandom));
            else if (pick < 80)
                send_event(cwcc_pkg::FUNC_PEER_ADJUST, rand_amount(), LEN_W'($urandom));
            else if (pick < 86)
                send_event(cwcc_pkg::FUNC_SUCCESS, $urandom, LEN_W'($urandom));
            else if (pick < 89)
                send_event(cwcc_pkg::FUNC_CLOSED, $urandom, LEN_W'($urandom));
            else if (pick < 92)
                send_event(cwcc_pkg::FUNC_OPEN_REQ, $urandom, LEN_W'($urandom));
            else if (pick < 95)
                send_event(cwcc_pkg::FUNC_OPEN_CONFIRM, rand_amount(), rand_length());
            else
                send_event(3'($urandom_range(7, 0)), $urandom, LEN_W'($urandom));
        end
    endtask

    task automatic test_directed_events();
        send_event(cwcc_pkg::FUNC_POP, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_PUSH, $urandom, '0);
        send_event(cwcc_pkg::FUNC_DATA_IN, $urandom, '1);
        send_event(cwcc_pkg::FUNC_SUCCESS, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_OPEN_CONFIRM, 32'd100, '1);
        send_event(cwcc_pkg::FUNC_PUSH, $urandom, '1);
        send_event(cwcc_pkg::FUNC_PUSH, $urandom, LEN_W'(99));
        send_event(cwcc_pkg::FUNC_PUSH, $urandom, LEN_W'(100));
        send_event(cwcc_pkg::FUNC_PUSH, $urandom, '0);
        send_event(cwcc_pkg::FUNC_POP, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_POP, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_PEER_ADJUST, 32'hFFFF_FFFF, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_PEER_ADJUST, 32'd1, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_POP, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_POP, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_POP, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_DATA_IN, $urandom, '0);
        send_event(cwcc_pkg::FUNC_CLOSED, $urandom, LEN_W'($urandom));
        repeat (5) send_event(cwcc_pkg::FUNC_DATA_IN, $urandom, '1);
        send_event(cwcc_pkg::FUNC_OPEN_REQ, $urandom, LEN_W'($urandom));
    endtask

    task automatic test_backpressure();
        int saved_idle;
        send_event(cwcc_pkg::FUNC_OPEN_REQ, $urandom, LEN_W'($urandom));
        send_event(cwcc_pkg::FUNC_OPEN_CONFIRM, 32'hFFFF_0000, '1);
        send_event(cwcc_pkg::FUNC_SUCCESS, $urandom, LEN_W'($urandom));
        saved_idle = send_idle_pct;
        send_idle_pct = 0;
        holdoff_cycles = 60;
        holdoff_seq++;
        repeat (cwcc_pkg::QUEUE_DEPTH + 1)
            send_event(cwcc_pkg::FUNC_PUSH, $urandom, LEN_W'($urandom_range(262142, 0)));
        repeat (cwcc_pkg::QUEUE_DEPTH + 1)
            send_event(cwcc_pkg::FUNC_POP, $urandom, LEN_W'($urandom));
        send_idle_pct = saved_idle;
        wait_until_drained();
    endtask

    task automatic test_config_sweep();
        logic [31:0] ws_list[7];
        logic [31:0] mp_list[7];
        ws_list = '{32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1, 32'd65536,
                    $urandom_range(32'hFFFF_FFFF, 1), cwcc_pkg::WINDOW_SIZE_RESET};
        mp_list = '{32'd1, 32'd1, 32'd262143, 32'd262143, 32'd100,
                    $urandom_range(262143, 1), 32'(cwcc_pkg::MAX_PACKET_RESET)};
        for (int i = 0; i < 7; i++)
        begin
            write_register(cwcc_pkg::CFG_WINDOW_SIZE, ws_list[i]);
            write_register(cwcc_pkg::CFG_MAX_PACKET, mp_list[i]);
            random_session(90);
        end
    endtask

    task automatic test_random_traffic(input int sender_idle, input int receiver_idle,
                                       input int n_items);
        int target;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        target = items_sent + n_items;
        while (items_sent < target)
        begin
            if ($urandom_range(9, 0) < 3)
            begin
                write_register(cwcc_pkg::CFG_WINDOW_SIZE, $urandom_range(2, 0) == 0 ?
                               cwcc_pkg::WINDOW_SIZE_RESET :
                               $urandom_range(32'hFFFF_FFFF, 1));
                write_register(cwcc_pkg::CFG_MAX_PACKET, $urandom_range(262143, 1));
            end
            random_session($urandom_range(120, 20));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        evt_ch.valid = 1'b0;
        evt_ch.func = cwcc_pkg::FUNC_OPEN_REQ;
        evt_ch.amount = '0;
        evt_ch.length = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = cwcc_pkg::CFG_WINDOW_SIZE;
        cfg_ch.data = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 35;
        recv_idle_pct = 74;
        test_directed_events();
        test_backpressure();
        test_config_sweep();
        test_random_traffic(74, 35, 600);
        test_random_traffic(0, 0, 600);
        wait_until_drained();
        repeat (5) @(posedge clk);
        $display("Run covered %0d events and %0d checked results over %0d register writes.",
                 items_sent, results_checked, config_writes);
        $display("Seen: %0d window adjusts, %0d packets released, %0d pushes refused,",
                 adjusts_seen, pops_seen, rejects_seen);
        $display("and %0d underruns.", underruns_seen);
        if (error_count == 0)
            $display("** channel_window_credit_control: PASSED **");
        else
            $display("** channel_window_credit_control: FAILED **");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, awaited_results.size());
        $display("** channel_window_credit_control: FAILED **");
        $finish;
    end

endmodule

### channel_window_credit_control.f
src/cwcc_pkg.sv
src/cwcc_ifs.sv
src/cwcc_ram.sv
src/cwcc_queue.sv
src/channel_window_credit_control.sv
bench/channel_window_credit_control_test.sv
